FILE: rtl/etc2_rgb8_block_decoder_top_assert.svh
// Assertion macros used by the block decoder checker.
`ifndef ETC2_RGB8_BLOCK_DECODER_TOP_ASSERT_SVH
`define ETC2_RGB8_BLOCK_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ETC2_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("etc2 decoder check failed (same cycle)");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ETC2_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("etc2 decoder check failed (next cycle)");

`endif

FILE: rtl/etc2rgb_pkg.sv
// Types, tables and helper functions of the ETC2 RGB8 block decoder.
package etc2rgb_pkg;

  typedef enum logic [2:0] {
    MODE_INDIV  = 3'd0,
    MODE_DIFF   = 3'd1,
    MODE_T      = 3'd2,
    MODE_H      = 3'd3,
    MODE_PLANAR = 3'd4
  } mode_e;

  // Per-block decode results handed from the front end to the pixel engine.
  typedef struct packed {
    mode_e                  mode;
    logic                   flip;
    logic [2:0]             tab0;
    logic [2:0]             tab1;
    logic [1:0][2:0][7:0]   base;
    logic [3:0][2:0][7:0]   paint;
    logic [2:0][8:0]        dh;
    logic [2:0][8:0]        dv;
    logic [2:0][10:0]       pc;
    logic [15:0]            idx_msb;
    logic [15:0]            idx_lsb;
  } blk_t;

  localparam logic [7:0] ModLarge [8] = '{8'd8, 8'd17, 8'd29, 8'd42,
                                          8'd60, 8'd80, 8'd106, 8'd183};
  localparam logic [7:0] ModSmall [8] = '{8'd2, 8'd5, 8'd9, 8'd13,
                                          8'd18, 8'd24, 8'd33, 8'd47};
  localparam logic [6:0] DistTab [8] = '{7'd3, 7'd6, 7'd11, 7'd16,
                                         7'd23, 7'd32, 7'd41, 7'd64};
  localparam logic [1:0] SelMap [4] = '{2'd2, 2'd3, 2'd1, 2'd0};

  function automatic logic [7:0] ex4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] ex5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] ex6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [7:0] ex7(input logic [6:0] v);
    return {v, v[6]};
  endfunction

  function automatic logic [7:0] clamp10(input logic signed [9:0] v);
    logic [7:0] r;
    if (v < 10'sd0) begin
      r = 8'd0;
    end else if (v > 10'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // Modifier for an ETC1 table and a raw 2-bit pixel index.
  function automatic logic signed [8:0] mod_val(input logic [2:0] tab,
                                                input logic [1:0] idx);
    logic [1:0]        sel;
    logic signed [8:0] m;
    sel = SelMap[idx];
    case (sel)
      2'd0:    m = -$signed({1'b0, ModLarge[tab]});
      2'd1:    m = -$signed({1'b0, ModSmall[tab]});
      2'd2:    m = $signed({1'b0, ModSmall[tab]});
      default: m = $signed({1'b0, ModLarge[tab]});
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/etc2rgb_front.sv
// Front end: classifies a compressed block and works out its per-block colors.
module etc2rgb_front (
  input  logic [63:0]        blk_i,
  output etc2rgb_pkg::blk_t  entry_o
);

  logic [4:0]            r5, g5, b5;
  logic signed [6:0]     rs, gs, bs;
  etc2rgb_pkg::mode_e    mode;
  logic [2:0][7:0]       c0, c1, po, ph, pv;
  logic [6:0]            spread;
  logic [11:0]           k0, k1;
  logic [2:0]            di;

  always_comb begin
    r5 = blk_i[63:59];
    g5 = blk_i[55:51];
    b5 = blk_i[47:43];
    rs = $signed({2'b00, r5}) + $signed({{4{blk_i[58]}}, blk_i[58:56]});
    gs = $signed({2'b00, g5}) + $signed({{4{blk_i[50]}}, blk_i[50:48]});
    bs = $signed({2'b00, b5}) + $signed({{4{blk_i[42]}}, blk_i[42:40]});

    // A sum outside 0..31 shows up in the two top bits.
    if (!blk_i[33]) begin
      mode = etc2rgb_pkg::MODE_INDIV;
    end else if (rs[6:5] != 2'b00) begin
      mode = etc2rgb_pkg::MODE_T;
    end else if (gs[6:5] != 2'b00) begin
      mode = etc2rgb_pkg::MODE_H;
    end else if (bs[6:5] != 2'b00) begin
      mode = etc2rgb_pkg::MODE_PLANAR;
    end else begin
      mode = etc2rgb_pkg::MODE_DIFF;
    end

    entry_o = '0;
    entry_o.mode    = mode;
    entry_o.flip    = blk_i[32];
    entry_o.tab0    = blk_i[39:37];
    entry_o.tab1    = blk_i[36:34];
    entry_o.idx_msb = blk_i[31:16];
    entry_o.idx_lsb = blk_i[15:0];

    if (mode == etc2rgb_pkg::MODE_INDIV) begin
      entry_o.base[0][0] = etc2rgb_pkg::ex4(blk_i[63:60]);
      entry_o.base[1][0] = etc2rgb_pkg::ex4(blk_i[59:56]);
      entry_o.base[0][1] = etc2rgb_pkg::ex4(blk_i[55:52]);
      entry_o.base[1][1] = etc2rgb_pkg::ex4(blk_i[51:48]);
      entry_o.base[0][2] = etc2rgb_pkg::ex4(blk_i[47:44]);
      entry_o.base[1][2] = etc2rgb_pkg::ex4(blk_i[43:40]);
    end else begin
      entry_o.base[0][0] = etc2rgb_pkg::ex5(r5);
      entry_o.base[1][0] = etc2rgb_pkg::ex5(rs[4:0]);
      entry_o.base[0][1] = etc2rgb_pkg::ex5(g5);
      entry_o.base[1][1] = etc2rgb_pkg::ex5(gs[4:0]);
      entry_o.base[0][2] = etc2rgb_pkg::ex5(b5);
      entry_o.base[1][2] = etc2rgb_pkg::ex5(bs[4:0]);
    end

    // T and H modes: two base colors and a distance give four paint colors.
    k0 = {blk_i[62:59], blk_i[58:56], blk_i[52], blk_i[51], blk_i[49:47]};
    k1 = {blk_i[46:43], blk_i[42:39], blk_i[38:35]};
    if (mode == etc2rgb_pkg::MODE_T) begin
      c0[0] = etc2rgb_pkg::ex4({blk_i[60:59], blk_i[57:56]});
      c0[1] = etc2rgb_pkg::ex4(blk_i[55:52]);
      c0[2] = etc2rgb_pkg::ex4(blk_i[51:48]);
      c1[0] = etc2rgb_pkg::ex4(blk_i[47:44]);
      c1[1] = etc2rgb_pkg::ex4(blk_i[43:40]);
      c1[2] = etc2rgb_pkg::ex4(blk_i[39:36]);
      di    = {blk_i[35:34], blk_i[32]};
    end else begin
      c0[0] = etc2rgb_pkg::ex4(k0[11:8]);
      c0[1] = etc2rgb_pkg::ex4(k0[7:4]);
      c0[2] = etc2rgb_pkg::ex4(k0[3:0]);
      c1[0] = etc2rgb_pkg::ex4(k1[11:8]);
      c1[1] = etc2rgb_pkg::ex4(k1[7:4]);
      c1[2] = etc2rgb_pkg::ex4(k1[3:0]);
      di    = {blk_i[34], blk_i[32], (k0 >= k1)};
    end
    spread = etc2rgb_pkg::DistTab[di];
    for (int c = 0; c < 3; c++) begin
      if (mode == etc2rgb_pkg::MODE_T) begin
        entry_o.paint[0][c] = c0[c];
        entry_o.paint[1][c] = etc2rgb_pkg::clamp10($signed({2'b00, c1[c]}) +
                                                   $signed({3'b000, spread}));
        entry_o.paint[2][c] = c1[c];
        entry_o.paint[3][c] = etc2rgb_pkg::clamp10($signed({2'b00, c1[c]}) -
                                                   $signed({3'b000, spread}));
      end else begin
        entry_o.paint[0][c] = etc2rgb_pkg::clamp10($signed({2'b00, c0[c]}) +
                                                   $signed({3'b000, spread}));
        entry_o.paint[1][c] = etc2rgb_pkg::clamp10($signed({2'b00, c0[c]}) -
                                                   $signed({3'b000, spread}));
        entry_o.paint[2][c] = etc2rgb_pkg::clamp10($signed({2'b00, c1[c]}) +
                                                   $signed({3'b000, spread}));
        entry_o.paint[3][c] = etc2rgb_pkg::clamp10($signed({2'b00, c1[c]}) -
                                                   $signed({3'b000, spread}));
      end
    end

    // Planar: origin, horizontal and vertical colors reduced to gradients.
    po[0] = etc2rgb_pkg::ex6(blk_i[62:57]);
    po[1] = etc2rgb_pkg::ex7({blk_i[56], blk_i[54:49]});
    po[2] = etc2rgb_pkg::ex6({blk_i[48], blk_i[44:43], blk_i[41:39]});
    ph[0] = etc2rgb_pkg::ex6({blk_i[38:34], blk_i[32]});
    ph[1] = etc2rgb_pkg::ex7(blk_i[31:25]);
    ph[2] = etc2rgb_pkg::ex6(blk_i[24:19]);
    pv[0] = etc2rgb_pkg::ex6(blk_i[18:13]);
    pv[1] = etc2rgb_pkg::ex7(blk_i[12:6]);
    pv[2] = etc2rgb_pkg::ex6(blk_i[5:0]);
    for (int c = 0; c < 3; c++) begin
      entry_o.dh[c] = {1'b0, ph[c]} - {1'b0, po[c]};
      entry_o.dv[c] = {1'b0, pv[c]} - {1'b0, po[c]};
      entry_o.pc[c] = {1'b0, po[c], 2'b10};
    end
  end

endmodule

FILE: rtl/etc2rgb_queue.sv
// Short register queue of decoded blocks between the front end and the pixel engine.
module etc2rgb_queue #(
  parameter int Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  etc2rgb_pkg::blk_t  push_data_i,
  input  logic               pop_i,
  output etc2rgb_pkg::blk_t  pop_data_o,
  output logic               empty_o,
  output logic               full_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  etc2rgb_pkg::blk_t mem_q [Depth];
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == CW'(Depth));
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/etc2rgb_back.sv
// Pixel engine: walks the sixteen pixels of a decoded block, one per cycle.
module etc2rgb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  etc2rgb_pkg::blk_t  entry_i,
  output logic               pop_o,
  output logic               valid_o,
  output logic [1:0]         pixel_x_o,
  output logic [1:0]         pixel_y_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [2:0]         block_mode_o,
  output logic               last_pixel_o
);

  etc2rgb_pkg::blk_t blk_q;
  logic              active_q, active_d;
  logic [3:0]        k_q, k_d;
  logic              valid_q;
  logic [1:0]        x_q, y_q;
  logic [2:0][7:0]   col_q, col_d;
  logic [2:0]        mode_q;
  logic              last_q;

  logic [1:0]        x, y;
  logic [3:0]        pos;
  logic [1:0]        idx;
  logic              sub;
  logic [2:0]        tab;
  logic signed [8:0] m;

  // The next block is taken on the last pixel of the current one, so blocks run gapless.
  assign pop_o = !empty_i && (!active_q || (k_q == 4'd15));

  always_comb begin
    active_d = active_q;
    k_d      = k_q;
    if (pop_o) begin
      active_d = 1'b1;
      k_d      = 4'd0;
    end else if (active_q) begin
      k_d = k_q + 4'd1;
      if (k_q == 4'd15) begin
        active_d = 1'b0;
      end
    end
  end

  always_comb begin
    logic signed [9:0]  e;
    logic signed [12:0] s;
    logic signed [10:0] sh;
    x   = k_q[1:0];
    y   = k_q[3:2];
    pos = {x, y};
    idx = {blk_q.idx_msb[pos], blk_q.idx_lsb[pos]};
    sub = blk_q.flip ? y[1] : x[1];
    tab = sub ? blk_q.tab1 : blk_q.tab0;
    m   = etc2rgb_pkg::mod_val(tab, idx);
    for (int c = 0; c < 3; c++) begin
      e = $signed({2'b00, blk_q.base[sub][c]}) + $signed({m[8], m});
      s = $signed({2'b00, blk_q.pc[c]});
      if (x[0]) s = s + $signed({{4{blk_q.dh[c][8]}}, blk_q.dh[c]});
      if (x[1]) s = s + $signed({{3{blk_q.dh[c][8]}}, blk_q.dh[c], 1'b0});
      if (y[0]) s = s + $signed({{4{blk_q.dv[c][8]}}, blk_q.dv[c]});
      if (y[1]) s = s + $signed({{3{blk_q.dv[c][8]}}, blk_q.dv[c], 1'b0});
      sh = 11'(s >>> 2);
      case (blk_q.mode)
        etc2rgb_pkg::MODE_INDIV, etc2rgb_pkg::MODE_DIFF: begin
          col_d[c] = etc2rgb_pkg::clamp10(e);
        end
        etc2rgb_pkg::MODE_T, etc2rgb_pkg::MODE_H: begin
          col_d[c] = blk_q.paint[idx][c];
        end
        default: begin
          if (sh < 11'sd0) begin
            col_d[c] = 8'd0;
          end else if (sh > 11'sd255) begin
            col_d[c] = 8'd255;
          end else begin
            col_d[c] = sh[7:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      k_q      <= 4'd0;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      k_q      <= k_d;
      valid_q  <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      blk_q <= entry_i;
    end
    x_q    <= x;
    y_q    <= y;
    col_q  <= col_d;
    mode_q <= blk_q.mode;
    last_q <= (k_q == 4'd15);
  end

  assign valid_o      = valid_q;
  assign pixel_x_o    = x_q;
  assign pixel_y_o    = y_q;
  assign red_o        = col_q[0];
  assign green_o      = col_q[1];
  assign blue_o       = col_q[2];
  assign block_mode_o = mode_q;
  assign last_pixel_o = valid_q && last_q;

endmodule

FILE: rtl/etc2_rgb8_block_decoder_top.sv
// Top level of the ETC2 RGB8 block decoder: front end, block queue and pixel engine.
// A request is written into the block queue, then loaded into the pixel engine's block
// register, and its first pixel is driven from the registered output stage.
// Throughput: one pixel per cycle, set by the pixel engine.
// Requests are taken while a block is being emitted; busy rises only when the queue is full.
// The receiver cannot stall, so valid_o strobes each pixel for exactly one cycle.
// Reset (rst_ni low, asynchronous) empties the queue and idles the pixel engine.
module etc2_rgb8_block_decoder_top #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] block_bits_i,
  output logic        valid_o,
  output logic [1:0]  pixel_x_o,
  output logic [1:0]  pixel_y_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [2:0]  block_mode_o,
  output logic        last_pixel_o
);

  // The front end is purely combinational: a request is decoded in the cycle it
  // is accepted and the per-block colors are written straight into the queue.
  etc2rgb_pkg::blk_t front_entry;
  etc2rgb_pkg::blk_t head_entry;
  logic              push;
  logic              pop;
  logic              empty;
  logic              full;

  assign busy = full;
  assign push = start && !full;

  etc2rgb_front u_front (
    .blk_i   (block_bits_i),
    .entry_o (front_entry)
  );

  // The queue decouples acceptance from pixel output, so a new request is
  // taken while the engine is still emitting the previous block.
  etc2rgb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_entry),
    .pop_i       (pop),
    .pop_data_o  (head_entry),
    .empty_o     (empty),
    .full_o      (full)
  );

  // The pixel engine holds one block and emits its pixels in raster order,
  // row by row, through a registered output stage.
  etc2rgb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .entry_i      (head_entry),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .block_mode_o (block_mode_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

FILE: rtl/etc2rgb_checker.sv
// Port-level checker of the block decoder and its bind to the top level.
`include "etc2_rgb8_block_decoder_top_assert.svh"

module etc2rgb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic [1:0]  pixel_x_o,
  input logic [1:0]  pixel_y_o,
  input logic [2:0]  block_mode_o,
  input logic        last_pixel_o
);

  // The last pixel of a block is the bottom-right corner.
  `ETC2_ASSERT_IMP(a_last_corner, last_pixel_o, valid_o && pixel_x_o == 2'd3 && pixel_y_o == 2'd3)
  // A block's sixteen pixels come out on consecutive cycles.
  `ETC2_ASSERT_NXT(a_block_run, valid_o && !last_pixel_o, valid_o)
  // Columns step by one, wrapping into the next row.
  `ETC2_ASSERT_NXT(a_raster_x, valid_o && !last_pixel_o, pixel_x_o == $past(pixel_x_o) + 2'd1)
  // All pixels of a block report the same mode.
  `ETC2_ASSERT_NXT(a_mode_hold, valid_o && !last_pixel_o, block_mode_o == $past(block_mode_o))

endmodule

bind etc2_rgb8_block_decoder_top etc2rgb_checker u_etc2rgb_checker (.*);
